/* hdl/kvt_pkg.sv */
// Package for the key-value table: item and result structs, outcome codes
// and fixed field widths. No dependencies.
package kvt_pkg;

  localparam int KEY_BITS   = 64;
  localparam int VALUE_BITS = 64;
  localparam int CAP_BITS   = 5;
  localparam int SLOT_BITS  = 4;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  localparam logic [2:0] OUT_UPDATED   = 3'd0;
  localparam logic [2:0] OUT_INSERTED  = 3'd1;
  localparam logic [2:0] OUT_FULL      = 3'd2;
  localparam logic [2:0] OUT_FOUND     = 3'd3;
  localparam logic [2:0] OUT_NOT_FOUND = 3'd4;

  localparam logic ACT_SET = 1'b0;
  localparam logic ACT_GET = 1'b1;

  typedef struct packed {
    logic                  action;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]            outcome;
    logic [SLOT_BITS-1:0]  slot;
    logic [VALUE_BITS-1:0] read_value;
  } result_t;

endpackage

/* hdl/kvt_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module kvt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/key_value_table_set_get.sv */
// Key-value table with linear search over the filled slots, filled in order
// of first insertion. Keys and values live in two synchronous RAMs read at the
// same slot each cycle, so the scan compares one slot per cycle. An item taken
// when fill_count slots are filled produces its single result, on done, once the
// key is compared equal in slot h, or once all filled slots have been compared
// (with no compare for an empty table) when it is not; busy is high in between.
// The result is held for exactly one cycle and must be taken then. A set of a
// new key inserts it only while fill_count is below min(capacity, DEPTH).
// Depends on kvt_pkg and kvt_ram.
module key_value_table_set_get #(
  parameter int DEPTH       = 16,
  parameter int KEY_WIDTH   = 64,
  parameter int VALUE_WIDTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  kvt_pkg::in_item_t                   item,
  input  logic                                cfg_we,
  input  logic [kvt_pkg::CAP_BITS-1:0]        cfg_wdata,
  output logic                                done,
  output kvt_pkg::result_t                    result
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);
  localparam int CW = (FW > kvt_pkg::CAP_BITS) ? FW : kvt_pkg::CAP_BITS;
  localparam int SW = (AW > kvt_pkg::SLOT_BITS) ? AW : kvt_pkg::SLOT_BITS;

  typedef enum logic {IDLE, SCAN} state_t;

  state_t                       state;
  logic [kvt_pkg::CAP_BITS-1:0] capacity;
  logic [FW-1:0]                fill_count;
  logic [FW-1:0]                issue_idx;
  logic                         pend_valid;
  logic [AW-1:0]                pend_idx;
  logic                         action_q;
  logic [KEY_WIDTH-1:0]         key_q;
  logic [VALUE_WIDTH-1:0]       value_q;

  logic [KEY_WIDTH-1:0]         key_rdata;
  logic [VALUE_WIDTH-1:0]       value_rdata;

  logic                         scanning;
  logic                         hit;
  logic                         miss;
  logic                         can_insert;
  logic                         rd_en;
  logic                         key_we;
  logic                         value_we;
  logic [AW-1:0]                fill_addr;
  logic [AW-1:0]                value_waddr;
  logic [SW-1:0]                hit_slot_wide;
  logic [SW-1:0]                fill_slot_wide;

  assign scanning   = (state == SCAN);
  assign hit        = scanning && pend_valid && (key_rdata == key_q);
  // Nothing left to read and the last compare (if any) did not match.
  assign miss       = scanning && !hit && (issue_idx >= fill_count);
  assign can_insert = (CW'(fill_count) < CW'(capacity)) && (CW'(fill_count) < CW'(DEPTH));
  assign rd_en      = scanning && (issue_idx < fill_count);
  assign fill_addr  = fill_count[AW-1:0];

  assign key_we      = miss && (action_q == kvt_pkg::ACT_SET) && can_insert;
  assign value_we    = (action_q == kvt_pkg::ACT_SET) && (hit || key_we);
  assign value_waddr = hit ? pend_idx : fill_addr;

  assign hit_slot_wide  = SW'(pend_idx);
  assign fill_slot_wide = SW'(fill_addr);

  assign busy = scanning;

  kvt_ram #(
    .WIDTH(KEY_WIDTH),
    .DEPTH(DEPTH)
  ) u_key_ram (
    .clk  (clk),
    .we   (key_we),
    .waddr(fill_addr),
    .wdata(key_q),
    .re   (rd_en),
    .raddr(issue_idx[AW-1:0]),
    .rdata(key_rdata)
  );

  kvt_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(DEPTH)
  ) u_value_ram (
    .clk  (clk),
    .we   (value_we),
    .waddr(value_waddr),
    .wdata(value_q),
    .re   (rd_en),
    .raddr(issue_idx[AW-1:0]),
    .rdata(value_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      capacity   <= kvt_pkg::CAP_RESET;
      fill_count <= '0;
      pend_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      case (state)
        IDLE: begin
          if (start) begin
            action_q   <= item.action;
            key_q      <= item.key[KEY_WIDTH-1:0];
            value_q    <= item.write_value[VALUE_WIDTH-1:0];
            issue_idx  <= '0;
            pend_valid <= 1'b0;
            state      <= SCAN;
          end
        end
        SCAN: begin
          // The read issued this cycle is compared in the next one.
          pend_valid <= rd_en;
          pend_idx   <= issue_idx[AW-1:0];
          if (rd_en) begin
            issue_idx <= issue_idx + FW'(1);
          end
          if (hit || miss) begin
            state             <= IDLE;
            pend_valid        <= 1'b0;
            done              <= 1'b1;
            result.read_value <= '0;
            result.slot       <= '0;
            if (hit) begin
              result.slot <= hit_slot_wide[kvt_pkg::SLOT_BITS-1:0];
              if (action_q == kvt_pkg::ACT_SET) begin
                result.outcome <= kvt_pkg::OUT_UPDATED;
              end else begin
                result.outcome    <= kvt_pkg::OUT_FOUND;
                result.read_value <= kvt_pkg::VALUE_BITS'(value_rdata);
              end
            end else if (action_q == kvt_pkg::ACT_GET) begin
              result.outcome <= kvt_pkg::OUT_NOT_FOUND;
            end else if (can_insert) begin
              result.outcome <= kvt_pkg::OUT_INSERTED;
              result.slot    <= fill_slot_wide[kvt_pkg::SLOT_BITS-1:0];
              fill_count     <= fill_count + FW'(1);
            end else begin
              result.outcome <= kvt_pkg::OUT_FULL;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for key_value_table_set_get: directed and random
// set/get items with a predictor of the table. Depends on kvt_pkg and the RTL.
module tb_top;

  localparam int DEPTH        = 16;
  localparam int POOL_SIZE    = 24;
  localparam int PHASE_ITEMS  = 170;
  localparam int DRAIN_CYCLES = DEPTH + 4;
  localparam int MAX_REPORTS  = 10;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [kvt_pkg::KEY_BITS-1:0] KEY_X = 64'h0123_4567_89AB_CDEF;
  localparam logic [kvt_pkg::KEY_BITS-1:0] KEY_Y = 64'hFEDC_BA98_7654_3210;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         busy;
  kvt_pkg::in_item_t            item = '0;
  logic                         cfg_we = 1'b0;
  logic [kvt_pkg::CAP_BITS-1:0] cfg_wdata = kvt_pkg::CAP_RESET;
  logic                         done;
  kvt_pkg::result_t             result;

  key_value_table_set_get #(
    .DEPTH      (DEPTH),
    .KEY_WIDTH  (kvt_pkg::KEY_BITS),
    .VALUE_WIDTH(kvt_pkg::VALUE_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .done     (done),
    .result   (result)
  );

  always #1 clk = ~clk;

  // Predicted contents of the table.
  logic [kvt_pkg::KEY_BITS-1:0]   table_keys[DEPTH];
  logic [kvt_pkg::VALUE_BITS-1:0] table_values[DEPTH];
  int unsigned                    table_fill = 0;
  logic [kvt_pkg::CAP_BITS-1:0]   table_cap = kvt_pkg::CAP_RESET;

  kvt_pkg::result_t               pending_results[$];
  kvt_pkg::result_t               oldest_result;
  logic [kvt_pkg::KEY_BITS-1:0]   key_pool[POOL_SIZE];
  int unsigned                    mismatch_count = 0;
  int unsigned                    cycle_count = 0;
  bit                             gaps_off = 1'b0;

  function automatic kvt_pkg::result_t predict_lookup(kvt_pkg::in_item_t it);
    int               hit;
    int unsigned      eff_cap;
    kvt_pkg::result_t r;
    hit = -1;
    for (int i = 0; i < table_fill; i++) begin
      if (hit < 0 && table_keys[i] == it.key) hit = i;
    end
    eff_cap = (table_cap < DEPTH) ? table_cap : DEPTH;
    r = '0;
    if (it.action == kvt_pkg::ACT_SET) begin
      if (hit >= 0) begin
        table_values[hit] = it.write_value;
        r.outcome = kvt_pkg::OUT_UPDATED;
        r.slot = kvt_pkg::SLOT_BITS'(hit);
      end else if (table_fill < eff_cap) begin
        table_keys[table_fill] = it.key;
        table_values[table_fill] = it.write_value;
        r.outcome = kvt_pkg::OUT_INSERTED;
        r.slot = kvt_pkg::SLOT_BITS'(table_fill);
        table_fill++;
      end else begin
        r.outcome = kvt_pkg::OUT_FULL;
      end
    end else begin
      if (hit >= 0) begin
        r.outcome = kvt_pkg::OUT_FOUND;
        r.slot = kvt_pkg::SLOT_BITS'(hit);
        r.read_value = table_values[hit];
      end else begin
        r.outcome = kvt_pkg::OUT_NOT_FOUND;
      end
    end
    return r;
  endfunction

  function automatic kvt_pkg::in_item_t make_item(logic act,
                                                  logic [kvt_pkg::KEY_BITS-1:0] k,
                                                  logic [kvt_pkg::VALUE_BITS-1:0] v);
    kvt_pkg::in_item_t it;
    it.action = act;
    it.key = k;
    it.write_value = v;
    return it;
  endfunction

  // Called at a rising edge; returns at the edge that accepts the item.
  task automatic send_item(kvt_pkg::in_item_t it);
    int unsigned gap;
    gap = gaps_off ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(negedge clk); while (busy);
    @(posedge clk);
    pending_results.push_back(predict_lookup(it));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [kvt_pkg::CAP_BITS-1:0] cap);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    table_cap = cap;
  endtask

  // With no room at all, every new key is refused and nothing is found.
  task automatic test_empty_table();
    write_capacity('0);
    send_item(make_item(kvt_pkg::ACT_SET, '0, '1));
    send_item(make_item(kvt_pkg::ACT_GET, '0, '1));
    send_item(make_item(kvt_pkg::ACT_SET, '1, '0));
  endtask

  task automatic test_insert_update_get();
    write_capacity(kvt_pkg::CAP_BITS'(2));
    send_item(make_item(kvt_pkg::ACT_SET, '0, '0));
    send_item(make_item(kvt_pkg::ACT_SET, '1, '1));
    send_item(make_item(kvt_pkg::ACT_SET, KEY_X, 64'hDEAD_BEEF_0000_0001));
    send_item(make_item(kvt_pkg::ACT_GET, '0, '1));
    send_item(make_item(kvt_pkg::ACT_GET, '1, '0));
    send_item(make_item(kvt_pkg::ACT_SET, '0, 64'h5555_5555_5555_5555));
    send_item(make_item(kvt_pkg::ACT_GET, '0, '0));
    send_item(make_item(kvt_pkg::ACT_GET, KEY_X, 64'hAAAA_AAAA_AAAA_AAAA));
  endtask

  // Capacity above the depth is clamped; capacity below the fill count
  // still allows updates and lookups of the filled slots.
  task automatic test_capacity_limits();
    write_capacity('1);
    send_item(make_item(kvt_pkg::ACT_SET, KEY_X, 64'h0F0F_0F0F_0F0F_0F0F));
    send_item(make_item(kvt_pkg::ACT_GET, KEY_X, '0));
    write_capacity(kvt_pkg::CAP_BITS'(1));
    send_item(make_item(kvt_pkg::ACT_SET, KEY_Y, '1));
    send_item(make_item(kvt_pkg::ACT_SET, '1, '0));
    send_item(make_item(kvt_pkg::ACT_GET, '1, '1));
    send_item(make_item(kvt_pkg::ACT_GET, KEY_Y, '1));
  endtask

  task automatic test_random_mix();
    logic [kvt_pkg::CAP_BITS-1:0] caps[6];
    kvt_pkg::in_item_t            it;
    caps = '{kvt_pkg::CAP_BITS'(6), kvt_pkg::CAP_BITS'(3), kvt_pkg::CAP_BITS'(16),
             kvt_pkg::CAP_BITS'(0), '1, kvt_pkg::CAP_BITS'(10)};
    foreach (caps[p]) begin
      write_capacity(caps[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 25 == 0) gaps_off = ($urandom_range(0, 3) == 0);
        it.action = 1'($urandom_range(0, 1));
        // Most keys come from a small pool so that hits and updates are common.
        if ($urandom_range(0, 9) < 8) it.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else it.key = {$urandom, $urandom};
        case ($urandom_range(0, 7))
          0: it.write_value = '0;
          1: it.write_value = '1;
          default: it.write_value = {$urandom, $urandom};
        endcase
        send_item(it);
      end
    end
    gaps_off = 1'b0;
  endtask

  always @(negedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("unexpected result: outcome %0d slot %0d value %h",
                   result.outcome, result.slot, result.read_value);
        mismatch_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (result.outcome !== oldest_result.outcome || result.slot !== oldest_result.slot ||
            result.read_value !== oldest_result.read_value) begin
          if (mismatch_count < MAX_REPORTS)
            $display("mismatch: expected outcome %0d slot %0d value %h, got %0d %0d %h",
                     oldest_result.outcome, oldest_result.slot, oldest_result.read_value,
                     result.outcome, result.slot, result.read_value);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** key_value_table_set_get: FAILED **");
      $finish;
    end
  end

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = KEY_X;
    key_pool[3] = KEY_Y;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_insert_update_get();
    test_capacity_limits();
    test_random_mix();
    drain();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("** key_value_table_set_get: PASSED **");
    end else begin
      $display("** key_value_table_set_get: FAILED **");
    end
    $finish;
  end

endmodule
